@@ hdl/lst_pkg.sv @@
// Shared constants, codes and controller/datapath bundles for the lattice spanning test.
// No dependencies; every other file refers here by scoped name.
`default_nettype none

package lst_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int MAX_DIM   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  // coordinates run 0..MAX+1 and must also hold a raw 7-bit register value
  localparam int COORD_W   = ($clog2(MAX_DIM + 2) > 7) ? $clog2(MAX_DIM + 2) : 7;
  localparam int ROW_AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_AW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  localparam int OP_W      = 2;
  localparam int SITE_W    = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_W     = 13;

  localparam int MIN_ROWS  = 3;
  localparam int MIN_COLS  = 1;
  localparam int ROW_RESET = 10;
  localparam int COL_RESET = 10;

  localparam int WALK_LIMIT = 4 * MAX_ROWS * MAX_COLS + 8;
  localparam int STEP_W     = $clog2(WALK_LIMIT + 1);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_BLOCK = 2'd1,
    OP_FILL  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 1'd0,
    REG_COL_COUNT = 1'd1
  } reg_e;

  // row address source for the lattice memory
  typedef enum logic [2:0] {
    RD_SITE = 3'd0,
    RD_SCAN = 3'd1,
    RD_ROW0 = 3'd2,
    RD_ROW1 = 3'd3,
    RD_CAND = 3'd4
  } rd_sel_e;

  // heading table: up, left, down, right, repeated
  localparam logic signed [1:0] STEP_ROW [8] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0,
                                                 -2'sd1, 2'sd0, 2'sd1, 2'sd0};
  localparam logic signed [1:0] STEP_COL [8] = '{2'sd0, -2'sd1, 2'sd0, 2'sd1,
                                                 2'sd0, -2'sd1, 2'sd0, 2'sd1};

  typedef struct packed {
    logic    load;
    logic    clear;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    commit;
    logic    scan_chk;
    logic    walk_init;
    logic    col_next;
    logic    walk_begin;
    logic    try_rd;
    logic    try_chk;
    logic    step_inc;
    logic    set_spans;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic site_ok;
    logic walk_req;
    logic row_hit;
    logic scan_last;
    logic col_over;
    logic top_bit;
    logic try_hit;
    logic try_last;
    logic at_last_row;
    logic at_top;
    logic step_over;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/lst_intf.sv @@
// Channel interfaces: item in, result out, register write.
// Depends on lst_pkg for field widths.
`default_nettype none

interface lst_item_if;
  logic                       valid;
  logic                       ready;
  logic [lst_pkg::OP_W-1:0]   op;
  logic [lst_pkg::SITE_W-1:0] site_row;
  logic [lst_pkg::SITE_W-1:0] site_col;
  modport source (output valid, op, site_row, site_col, input ready);
  modport sink   (input valid, op, site_row, site_col, output ready);
endinterface

interface lst_result_if;
  logic                      valid;
  logic                      ready;
  logic                      accepted;
  logic [lst_pkg::CNT_W-1:0] filled_total;
  logic                      rows_all_occupied;
  logic                      spans;
  modport source (output valid, accepted, filled_total, rows_all_occupied, spans,
                  input ready);
  modport sink   (input valid, accepted, filled_total, rows_all_occupied, spans,
                  output ready);
endinterface

interface lst_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lst_pkg::CFG_IDX_W-1:0] index;
  logic [lst_pkg::CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/lst_dp.sv @@
// Datapath: lattice row memory with per-row valid bits, counters, walk registers,
// config registers and result register. Depends on lst_pkg.
`default_nettype none

module lst_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lst_pkg::cmd_t                 cmd_i,
  output lst_pkg::sts_t                      sts_o,
  input  wire logic [lst_pkg::OP_W-1:0]      in_op_i,
  input  wire logic [lst_pkg::SITE_W-1:0]    in_row_i,
  input  wire logic [lst_pkg::SITE_W-1:0]    in_col_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [lst_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [lst_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic                               out_accepted_o,
  output logic [lst_pkg::CNT_W-1:0]          out_total_o,
  output logic                               out_rows_o,
  output logic                               out_spans_o
);

  localparam int CW = lst_pkg::COORD_W;

  logic [lst_pkg::CFG_W-1:0]  row_count_q, col_count_q;
  logic [lst_pkg::CNT_W-1:0]  cnt_q;
  logic                       out_valid_q;
  logic [lst_pkg::OP_W-1:0]   op_q;
  logic [lst_pkg::SITE_W-1:0] site_r_q, site_c_q;
  logic                       accepted_q, allrows_q, spans_q;
  logic [CW-1:0]              scan_row_q, row_q, col_q, cr_q, cc_q;
  logic [1:0]                 d_q, k_q, cdir_q;
  logic                       inr_q;
  logic [lst_pkg::STEP_W-1:0] steps_q;
  logic                       out_acc_q, out_rows_q, out_spans_q;
  logic [lst_pkg::CNT_W-1:0]  out_total_q;

  logic [lst_pkg::MAX_COLS-1:0] filled_mem  [lst_pkg::MAX_ROWS];
  logic [lst_pkg::MAX_COLS-1:0] blocked_mem [lst_pkg::MAX_ROWS];
  logic [lst_pkg::MAX_ROWS-1:0] row_vld_q;
  logic [lst_pkg::MAX_COLS-1:0] rd_f_q, rd_b_q;
  logic                         rd_vld_q;

  logic [CW-1:0]                rc, ccnt, nr, nc;
  logic [lst_pkg::ROW_AW-1:0]   rd_addr, wr_addr;
  logic [lst_pkg::MAX_COLS-1:0] f_word, b_word, col_mask, site_hot, wr_f, wr_b;
  logic [lst_pkg::COL_AW-1:0]   site_bit;
  logic                         is_fill, free, wr_en;
  logic [1:0]                   dir;
  logic signed [1:0]            dr, dc;
  logic [CW-1:0]                cand_row, cand_col;
  logic                         cand_in;

  // saturated lattice size
  always_comb begin
    rc   = CW'(row_count_q);
    ccnt = CW'(col_count_q);
    if (rc < CW'(lst_pkg::MIN_ROWS))      nr = CW'(lst_pkg::MIN_ROWS);
    else if (rc > CW'(lst_pkg::MAX_ROWS)) nr = CW'(lst_pkg::MAX_ROWS);
    else                                  nr = rc;
    if (ccnt < CW'(lst_pkg::MIN_COLS))      nc = CW'(lst_pkg::MIN_COLS);
    else if (ccnt > CW'(lst_pkg::MAX_COLS)) nc = CW'(lst_pkg::MAX_COLS);
    else                                    nc = ccnt;
  end

  always_comb begin
    for (int j = 0; j < lst_pkg::MAX_COLS; j++) begin
      col_mask[j] = (CW'(j) < nc);
    end
  end

  // candidate site of the wall walk
  assign dir      = d_q + 2'd3 + k_q;
  assign dr       = lst_pkg::STEP_ROW[{1'b0, dir}];
  assign dc       = lst_pkg::STEP_COL[{1'b0, dir}];
  assign cand_row = row_q + {{(CW-2){dr[1]}}, dr};
  assign cand_col = col_q + {{(CW-2){dc[1]}}, dc};
  assign cand_in  = (cand_row >= CW'(1)) && (cand_row <= nr) &&
                    (cand_col >= CW'(1)) && (cand_col <= nc);

  always_comb begin
    case (cmd_i.rd_sel)
      lst_pkg::RD_SITE: rd_addr = lst_pkg::ROW_AW'(site_r_q - 7'd1);
      lst_pkg::RD_SCAN: rd_addr = lst_pkg::ROW_AW'(scan_row_q);
      lst_pkg::RD_ROW0: rd_addr = '0;
      lst_pkg::RD_ROW1: rd_addr = lst_pkg::ROW_AW'(1);
      lst_pkg::RD_CAND: rd_addr = lst_pkg::ROW_AW'(cand_row - CW'(1));
      default:          rd_addr = '0;
    endcase
  end

  // never-written rows read as blank
  assign f_word   = rd_vld_q ? rd_f_q : '0;
  assign b_word   = rd_vld_q ? rd_b_q : '0;
  assign site_bit = lst_pkg::COL_AW'(site_c_q - 7'd1);
  assign site_hot = lst_pkg::MAX_COLS'(1) << site_bit;
  assign is_fill  = (op_q == lst_pkg::OP_FILL);
  assign free     = !(f_word[site_bit] | b_word[site_bit]);
  assign wr_en    = cmd_i.commit && free;
  assign wr_addr  = lst_pkg::ROW_AW'(site_r_q - 7'd1);
  assign wr_f     = is_fill ? (f_word | site_hot) : f_word;
  assign wr_b     = is_fill ? b_word : (b_word | site_hot);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_f_q   <= filled_mem[rd_addr];
      rd_b_q   <= blocked_mem[rd_addr];
      rd_vld_q <= row_vld_q[rd_addr];
    end
    if (wr_en) begin
      filled_mem[wr_addr]  <= wr_f;
      blocked_mem[wr_addr] <= wr_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q   <= '0;
      cnt_q       <= '0;
      row_count_q <= lst_pkg::CFG_W'(lst_pkg::ROW_RESET);
      col_count_q <= lst_pkg::CFG_W'(lst_pkg::COL_RESET);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        row_vld_q <= '0;
        cnt_q     <= '0;
      end else if (wr_en) begin
        row_vld_q[wr_addr] <= 1'b1;
        if (is_fill) cnt_q <= cnt_q + 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lst_pkg::REG_ROW_COUNT: row_count_q <= cfg_data_i;
          lst_pkg::REG_COL_COUNT: col_count_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.out_load)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= in_op_i;
      site_r_q   <= in_row_i;
      site_c_q   <= in_col_i;
      accepted_q <= 1'b0;
      scan_row_q <= '0;
      allrows_q  <= 1'b1;
      spans_q    <= 1'b0;
    end
    if (cmd_i.clear) accepted_q <= 1'b1;
    if (wr_en)       accepted_q <= 1'b1;
    if (cmd_i.scan_chk) begin
      scan_row_q <= scan_row_q + 1'b1;
      if (!(|(f_word & col_mask))) allrows_q <= 1'b0;
    end
    if (cmd_i.walk_init) col_q <= CW'(1);
    if (cmd_i.col_next)  col_q <= col_q + 1'b1;
    if (cmd_i.walk_begin) begin
      row_q   <= CW'(2);
      d_q     <= 2'd2;
      k_q     <= 2'd0;
      steps_q <= '0;
    end
    if (cmd_i.try_rd) begin
      cr_q   <= cand_row;
      cc_q   <= cand_col;
      cdir_q <= dir;
      inr_q  <= cand_in;
    end
    if (cmd_i.try_chk) begin
      if (sts_o.try_hit) begin
        row_q <= cr_q;
        col_q <= cc_q;
        d_q   <= cdir_q;
      end else if (k_q == 2'd3) begin
        d_q <= d_q - 2'd1;   // no way out: heading as for the first try
      end else begin
        k_q <= k_q + 2'd1;
      end
    end
    if (cmd_i.step_inc) begin
      steps_q <= steps_q + 1'b1;
      k_q     <= 2'd0;
    end
    if (cmd_i.set_spans) spans_q <= 1'b1;
    if (cmd_i.out_load) begin
      out_acc_q   <= accepted_q;
      out_total_q <= cnt_q;
      out_rows_q  <= allrows_q;
      out_spans_q <= spans_q;
    end
  end

  always_comb begin
    sts_o.is_clear    = (op_q == lst_pkg::OP_CLEAR);
    sts_o.site_ok     = ((op_q == lst_pkg::OP_BLOCK) || (op_q == lst_pkg::OP_FILL)) &&
                        (site_r_q != '0) && (CW'(site_r_q) <= nr) &&
                        (site_c_q != '0) && (CW'(site_c_q) <= nc);
    sts_o.walk_req    = accepted_q && is_fill;
    sts_o.row_hit     = |(f_word & col_mask);
    sts_o.scan_last   = (scan_row_q == nr - CW'(1));
    sts_o.col_over    = (col_q > nc);
    sts_o.top_bit     = f_word[lst_pkg::COL_AW'(col_q - CW'(1))];
    sts_o.try_hit     = inr_q && f_word[lst_pkg::COL_AW'(cc_q - CW'(1))];
    sts_o.try_last    = (k_q == 2'd3);
    sts_o.at_last_row = (row_q == nr);
    sts_o.at_top      = (row_q == CW'(1));
    sts_o.step_over   = (steps_q >= lst_pkg::STEP_W'(lst_pkg::WALK_LIMIT));
    sts_o.out_busy    = out_valid_q && !out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign out_accepted_o = out_acc_q;
  assign out_total_o    = out_total_q;
  assign out_rows_o     = out_rows_q;
  assign out_spans_o    = out_spans_q;

endmodule

`default_nettype wire

@@ hdl/lst_ctrl.sv @@
// Controller: one-hot sequencer for update, row scan and wall walk.
// Depends on lst_pkg for the command and status bundles.
`default_nettype none

module lst_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire lst_pkg::sts_t sts_i,
  output lst_pkg::cmd_t      cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DECODE   = 12'b0000_0000_0010,
    S_COMMIT   = 12'b0000_0000_0100,
    S_SCAN_RD  = 12'b0000_0000_1000,
    S_SCAN_CHK = 12'b0000_0001_0000,
    S_W_COL    = 12'b0000_0010_0000,
    S_W_TOP    = 12'b0000_0100_0000,
    S_W_SEC    = 12'b0000_1000_0000,
    S_TRY_RD   = 12'b0001_0000_0000,
    S_TRY_CHK  = 12'b0010_0000_0000,
    S_STEP     = 12'b0100_0000_0000,
    S_FINISH   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_clear) begin
          cmd_o.clear = 1'b1;
          state_d     = S_SCAN_RD;
        end else if (sts_i.site_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = lst_pkg::RD_SITE;
          state_d      = S_COMMIT;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = lst_pkg::RD_SCAN;
        state_d      = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd_o.scan_chk = 1'b1;
        if (!sts_i.row_hit) begin
          state_d = S_FINISH;
        end else if (sts_i.scan_last) begin
          if (sts_i.walk_req) begin
            cmd_o.walk_init = 1'b1;
            state_d         = S_W_COL;
          end else begin
            state_d = S_FINISH;
          end
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_W_COL: begin
        if (sts_i.col_over) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = lst_pkg::RD_ROW0;
          state_d      = S_W_TOP;
        end
      end
      S_W_TOP: begin
        if (sts_i.top_bit) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = lst_pkg::RD_ROW1;
          state_d      = S_W_SEC;
        end else begin
          cmd_o.col_next = 1'b1;
          state_d        = S_W_COL;
        end
      end
      S_W_SEC: begin
        if (sts_i.top_bit) begin
          cmd_o.walk_begin = 1'b1;
          state_d          = S_TRY_RD;
        end else begin
          cmd_o.col_next = 1'b1;
          state_d        = S_W_COL;
        end
      end
      S_TRY_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = lst_pkg::RD_CAND;
        cmd_o.try_rd = 1'b1;
        state_d      = S_TRY_CHK;
      end
      S_TRY_CHK: begin
        cmd_o.try_chk = 1'b1;
        if (sts_i.try_hit || sts_i.try_last) state_d = S_STEP;
        else                                 state_d = S_TRY_RD;
      end
      S_STEP: begin
        if (sts_i.at_last_row) begin
          cmd_o.set_spans = 1'b1;
          state_d         = S_FINISH;
        end else if (sts_i.step_over) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.step_inc = 1'b1;
          if (sts_i.at_top) begin
            cmd_o.col_next = 1'b1;
            state_d        = S_W_COL;
          end else begin
            state_d = S_TRY_RD;
          end
        end
      end
      S_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/lattice_spanning_test.sv @@
// Site percolation spanning test: controller and datapath; needs lst_pkg, lst_intf, lst_ctrl, lst_dp.
// Sequence: decode, a read and write of the site when it is valid, then a row scan from row 0;
// the row scan stops at the first empty row. A fill that fills every row adds a wall walk that
// tries each top-row column in turn and, per walk step, up to four candidate sites (read, check).
// Throughput: one item at a time; the next beat is taken once the result is registered.
// Reset: lattice empty, count zero, row_count and col_count 10; no clearing pass.
`default_nettype none

module lattice_spanning_test (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  lst_item_if.sink      item_i,
  lst_result_if.source  result_o,
  lst_cfg_if.sink       cfg_i
);

  // Controller and datapath only talk through these two bundles.
  lst_pkg::cmd_t cmd;
  lst_pkg::sts_t sts;
  logic          in_ready;

  // Registers may change at any time the block is idle, so the write port never stalls.
  assign cfg_i.ready  = 1'b1;
  assign item_i.ready = in_ready;

  lst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the lattice as one memory row per lattice row, filled and
  // blocked bits side by side, with a valid flop per row so a clear resets only those flops.
  lst_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_op_i        (item_i.op),
    .in_row_i       (item_i.site_row),
    .in_col_i       (item_i.site_col),
    .cfg_we_i       (cfg_i.valid),
    .cfg_idx_i      (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .out_ready_i    (result_o.ready),
    .out_valid_o    (result_o.valid),
    .out_accepted_o (result_o.accepted),
    .out_total_o    (result_o.filled_total),
    .out_rows_o     (result_o.rows_all_occupied),
    .out_spans_o    (result_o.spans)
  );

endmodule

`default_nettype wire
